>>> hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes on the action field
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd2;

    localparam int CfgDataWidth = 16;

    // Register reset values
    localparam logic [6:0]  RST_TARGET_ADDRESS = 7'd0;
    localparam logic [7:0]  RST_PHASE_TICKS    = 8'd6;
    localparam logic [15:0] RST_ACK_TIMEOUT    = 16'd1000;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_address;
        logic [7:0] write_value;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_error;
    } t_out_item;

endpackage

>>> hw/rtl/i2c_master_register_access.sv
// Single-register I2C master sequencer, advanced by one tick per transaction.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): each transaction is one
// bus tick carrying an optional command (write or read register), the register
// address, the write byte and the sampled SDA level. A command is taken only
// while the sequencer is idle; otherwise it is ignored.
// Output channel (o_out_valid / i_out_ready / o_out_data): one result per input
// transaction with the SCL/SDA levels, SDA drive enable, busy, done pulse, the
// last read byte and the ACK error flag after that tick.
// Config port (i_cfg_we / i_cfg_index / i_cfg_data): target address, ticks per
// bus phase and ACK timeout; write only while no transaction is in flight.
//
// The result of a tick is registered, in the result register or the skid register.
// Throughput: one tick per cycle; the whole tick update is a single pass of
// the sequencer logic between the state registers and the result register.
// A two-entry output stage (result plus skid register) keeps o_in_ready a
// register: when the receiver stalls, one more tick is taken into the skid
// register and input then stalls until the receiver drains it.
// Reset (i_rst_n low, synchronous) returns to idle with SCL high, SDA high and
// driven, counters cleared, registers at their reset values, outputs empty.
module i2c_master_register_access (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  i2cm_pkg::t_in_item      i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output i2cm_pkg::t_out_item     o_out_data
);
    import i2cm_pkg::*;

    // Sequencer phases; waiting phases hold the pins for a delay count,
    // idle, byte end and read finish are zero-time steps.
    typedef enum logic [23:0] {
        PH_IDLE     = 24'h000001,
        PH_ST_A     = 24'h000002,
        PH_ST_B     = 24'h000004,
        PH_ST_C     = 24'h000008,
        PH_WB_A     = 24'h000010,
        PH_WB_LO    = 24'h000020,
        PH_WB_HI    = 24'h000040,
        PH_WB_ACKLO = 24'h000080,
        PH_WB_ACKHI = 24'h000100,
        PH_WB_POLL  = 24'h000200,
        PH_WB_END   = 24'h000400,
        PH_SP_A     = 24'h000800,
        PH_SP_B     = 24'h001000,
        PH_SP_C     = 24'h002000,
        PH_DONE     = 24'h004000,
        PH_RB_A     = 24'h008000,
        PH_RB_LO    = 24'h010000,
        PH_RB_HI    = 24'h020000,
        PH_RB_SAMP  = 24'h040000,
        PH_RB_NACK  = 24'h080000,
        PH_RB_C     = 24'h100000,
        PH_RB_D     = 24'h200000,
        PH_RB_E     = 24'h400000,
        PH_RB_F     = 24'h800000
    } t_phase;

    // Configuration registers
    logic [6:0]  r_target_addr;
    logic [7:0]  r_phase_ticks;
    logic [15:0] r_ack_timeout;

    // Sequencer state
    t_phase      r_phase,      n_phase;
    logic [2:0]  r_byte_idx,   n_byte_idx;
    logic [3:0]  r_bit_cnt,    n_bit_cnt;
    logic [7:0]  r_delay,      n_delay;
    logic [15:0] r_ack_wait,   n_ack_wait;
    logic [7:0]  r_shift,      n_shift;
    logic        r_cmd_read,   n_cmd_read;
    logic [7:0]  r_lat_reg,    n_lat_reg;
    logic [7:0]  r_lat_val,    n_lat_val;
    logic        r_err,        n_err;
    logic        r_scl,        n_scl;
    logic        r_sda,        n_sda;
    logic        r_drive,      n_drive;
    logic [7:0]  r_rd_byte,    n_rd_byte;

    // Output stage
    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        r_skid_valid;
    t_out_item   r_skid_data;

    logic        in_fire;
    logic        out_take;
    t_out_item   result;

    logic [7:0]  half_ticks;
    t_phase      cur_ph;
    logic        run_wait;
    logic [7:0]  wait_len;

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign half_ticks  = r_phase_ticks >> 1;

    // One tick of the sequencer: a pending delay just counts down; otherwise
    // resolve at most one zero-time step, then run the waiting step it leads to.
    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_bit_cnt  = r_bit_cnt;
        n_delay    = r_delay;
        n_ack_wait = r_ack_wait;
        n_shift    = r_shift;
        n_cmd_read = r_cmd_read;
        n_lat_reg  = r_lat_reg;
        n_lat_val  = r_lat_val;
        n_err      = r_err;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_drive    = r_drive;
        n_rd_byte  = r_rd_byte;
        run_wait   = 1'b0;
        wait_len   = '0;
        cur_ph     = r_phase;

        // Leave the stop hold once its count has run out
        if (cur_ph == PH_DONE && r_delay == '0) begin
            cur_ph = PH_IDLE;
        end

        if (r_delay != '0) begin
            n_delay = r_delay - 8'd1;
        end else begin
            run_wait = 1'b1;
            case (cur_ph)
                PH_IDLE: begin
                    if (i_in_data.action == ACT_WRITE || i_in_data.action == ACT_READ) begin
                        n_cmd_read = (i_in_data.action == ACT_READ);
                        n_lat_reg  = i_in_data.reg_address;
                        n_lat_val  = i_in_data.write_value;
                        n_err      = 1'b0;
                        n_byte_idx = 3'd0;
                        cur_ph     = PH_ST_A;
                    end else begin
                        run_wait = 1'b0;
                    end
                end
                PH_WB_END: begin
                    n_scl   = 1'b0;
                    n_drive = 1'b1;
                    if (r_err) begin
                        cur_ph = PH_SP_A;
                    end else if (r_byte_idx == 3'd0) begin
                        n_byte_idx = 3'd1;
                        n_shift    = r_lat_reg;
                        cur_ph     = PH_WB_A;
                    end else if (r_byte_idx == 3'd1) begin
                        n_byte_idx = 3'd2;
                        if (r_cmd_read) begin
                            cur_ph = PH_ST_A;    // repeated start
                        end else begin
                            n_shift = r_lat_val;
                            cur_ph  = PH_WB_A;
                        end
                    end else if (r_cmd_read) begin
                        n_byte_idx = 3'd4;
                        cur_ph     = PH_RB_A;
                    end else begin
                        cur_ph = PH_SP_A;
                    end
                end
                PH_RB_F: begin
                    n_rd_byte = r_shift;
                    cur_ph    = PH_SP_A;
                end
                default: begin
                end
            endcase

            n_phase = cur_ph;

            if (run_wait) begin
                case (cur_ph)
                    PH_ST_A: begin
                        n_sda = 1'b1; n_scl = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_ST_B;
                    end
                    PH_ST_B: begin
                        n_sda = 1'b0;
                        wait_len = r_phase_ticks; n_phase = PH_ST_C;
                    end
                    PH_ST_C: begin
                        n_scl = 1'b0;
                        if (n_byte_idx == 3'd2) begin
                            n_byte_idx = 3'd3;
                            n_shift    = {r_target_addr, 1'b1};
                        end else begin
                            n_shift    = {r_target_addr, 1'b0};
                        end
                        wait_len = r_phase_ticks; n_phase = PH_WB_A;
                    end
                    PH_WB_A: begin
                        n_drive = 1'b1; n_bit_cnt = '0;
                        wait_len = r_phase_ticks; n_phase = PH_WB_LO;
                    end
                    PH_WB_LO: begin
                        n_scl = 1'b0;
                        n_sda = n_shift[3'd7 - n_bit_cnt[2:0]];
                        wait_len = r_phase_ticks; n_phase = PH_WB_HI;
                    end
                    PH_WB_HI: begin
                        n_scl     = 1'b1;
                        n_bit_cnt = n_bit_cnt + 4'd1;
                        wait_len  = r_phase_ticks;
                        n_phase   = (n_bit_cnt >= 4'd8) ? PH_WB_ACKLO : PH_WB_LO;
                    end
                    PH_WB_ACKLO: begin
                        n_scl = 1'b0; n_drive = 1'b0;
                        wait_len = r_phase_ticks; n_phase = PH_WB_ACKHI;
                    end
                    PH_WB_ACKHI: begin
                        n_scl = 1'b1; n_ack_wait = '0;
                        wait_len = half_ticks; n_phase = PH_WB_POLL;
                    end
                    PH_WB_POLL: begin
                        if (i_in_data.sda_in && r_ack_wait < r_ack_timeout) begin
                            n_ack_wait = r_ack_wait + 16'd1;
                            wait_len   = 8'd1;
                            n_phase    = PH_WB_POLL;
                        end else begin
                            if (r_ack_wait >= r_ack_timeout) begin
                                n_err = 1'b1;
                            end
                            wait_len = half_ticks;
                            n_phase  = PH_WB_END;
                        end
                    end
                    PH_SP_A: begin
                        n_sda = 1'b0;
                        wait_len = r_phase_ticks; n_phase = PH_SP_B;
                    end
                    PH_SP_B: begin
                        n_scl = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_SP_C;
                    end
                    PH_SP_C: begin
                        n_sda = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_DONE;
                    end
                    PH_RB_A: begin
                        n_drive = 1'b0; n_bit_cnt = '0; n_shift = '0;
                        wait_len = r_phase_ticks; n_phase = PH_RB_LO;
                    end
                    PH_RB_LO: begin
                        n_scl = 1'b0;
                        wait_len = r_phase_ticks; n_phase = PH_RB_HI;
                    end
                    PH_RB_HI: begin
                        n_scl = 1'b1;
                        wait_len = half_ticks; n_phase = PH_RB_SAMP;
                    end
                    PH_RB_SAMP: begin
                        if (i_in_data.sda_in) begin
                            n_shift[3'd7 - r_bit_cnt[2:0]] = 1'b1;
                        end
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        wait_len  = half_ticks;
                        n_phase   = (n_bit_cnt >= 4'd8) ? PH_RB_NACK : PH_RB_LO;
                    end
                    PH_RB_NACK: begin
                        n_scl = 1'b0; n_drive = 1'b1; n_sda = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_RB_C;
                    end
                    PH_RB_C: begin
                        n_scl = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_RB_D;
                    end
                    PH_RB_D: begin
                        n_scl = 1'b0;
                        wait_len = r_phase_ticks; n_phase = PH_RB_E;
                    end
                    PH_RB_E: begin
                        n_sda = 1'b1;
                        wait_len = r_phase_ticks; n_phase = PH_RB_F;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                // A zero-length wait still lasts one tick; this tick is counted
                n_delay = (wait_len == '0) ? 8'd0 : wait_len - 8'd1;
            end
        end

        result.scl_level  = n_scl;
        result.sda_level  = n_sda;
        result.sda_drive  = n_drive;
        result.busy_res   = (n_phase != PH_IDLE);
        result.done_res   = (n_phase == PH_DONE) && (n_delay == '0);
        result.read_value = n_rd_byte;
        result.ack_error  = n_err;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_addr <= RST_TARGET_ADDRESS;
            r_phase_ticks <= RST_PHASE_TICKS;
            r_ack_timeout <= RST_ACK_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_ADDRESS: r_target_addr <= i_cfg_data[6:0];
                CFG_PHASE_TICKS:    r_phase_ticks <= i_cfg_data[7:0];
                CFG_ACK_TIMEOUT:    r_ack_timeout <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the sequencer on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_byte_idx <= '0;
            r_bit_cnt  <= '0;
            r_delay    <= '0;
            r_ack_wait <= '0;
            r_shift    <= '0;
            r_cmd_read <= 1'b0;
            r_lat_reg  <= '0;
            r_lat_val  <= '0;
            r_err      <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_drive    <= 1'b1;
            r_rd_byte  <= '0;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_bit_cnt  <= n_bit_cnt;
            r_delay    <= n_delay;
            r_ack_wait <= n_ack_wait;
            r_shift    <= n_shift;
            r_cmd_read <= n_cmd_read;
            r_lat_reg  <= n_lat_reg;
            r_lat_val  <= n_lat_val;
            r_err      <= n_err;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_drive    <= n_drive;
            r_rd_byte  <= n_rd_byte;
        end
    end

    // Output stage: fill the result register when free, else park in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_take) begin
                r_out_data <= result;
            end else begin
                r_skid_data <= result;
            end
        end else if (out_take && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    // Skid register only holds a result behind a full result register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the result register is empty");

    // Idle leaves no delay pending
    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_delay == '0))
        else $error("delay pending while idle");

    // Idle bus: SCL high, SDA high and driven
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda && r_drive))
        else $error("bus not released while idle");

    // Done pulse comes only with busy
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |-> r_out_data.busy_res)
        else $error("done without busy");

    // Byte index never passes the read data byte
    a_byte_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= 3'd4)
        else $error("byte index out of range");

endmodule

>>> tb/tb_i2c_master_register_access.sv
module tb_i2c_master_register_access;
    import i2cm_pkg::*;

    // Action code 3 carries no command; the sequencer treats it as none.
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Cycles without any accepted transaction before the run is abandoned.
    localparam int WATCHDOG_CYCLES = 5000;

    // Bus sequencer steps of the predictor.
    typedef enum logic [5:0] {
        BS_IDLE,
        BS_START_HI,
        BS_START_SDA,
        BS_START_SCL,
        BS_WR_SETUP,
        BS_WR_LOW,
        BS_WR_HIGH,
        BS_ACK_LOW,
        BS_ACK_HIGH,
        BS_ACK_POLL,
        BS_ACK_END,
        BS_STOP_SDA,
        BS_STOP_SCL,
        BS_STOP_REL,
        BS_DONE,
        BS_RD_SETUP,
        BS_RD_LOW,
        BS_RD_HIGH,
        BS_RD_SAMPLE,
        BS_NACK_LOW,
        BS_NACK_HIGH,
        BS_NACK_END,
        BS_NACK_REL,
        BS_RD_LATCH
    } t_bus_step;

    // Block ports; every input starts at a known value.
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [1:0]              i_cfg_index = CFG_TARGET_ADDRESS;
    logic [CfgDataWidth-1:0] i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    t_in_item                i_in_data   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_out_item               o_out_data;

    // Predictor copy of the configuration registers.
    logic [6:0]  dev_addr        = RST_TARGET_ADDRESS;
    logic [7:0]  ticks_per_phase = RST_PHASE_TICKS;
    logic [15:0] ack_limit       = RST_ACK_TIMEOUT;

    // Predictor copy of the sequencer state.
    t_bus_step   bus_step    = BS_IDLE;
    logic [2:0]  byte_num    = '0;
    logic [3:0]  bit_num     = '0;
    logic [7:0]  wait_left   = '0;
    logic [15:0] ack_polls   = '0;
    logic [7:0]  shifter     = '0;
    logic        cmd_is_read = 1'b0;
    logic [7:0]  cmd_reg     = '0;
    logic [7:0]  cmd_val     = '0;
    logic        nack_seen   = 1'b0;
    logic        scl_q       = 1'b1;
    logic        sda_q       = 1'b1;
    logic        drive_q     = 1'b1;
    logic [7:0]  last_read   = '0;

    // Ticks waiting to be sent, and pin/status results still owed by the block.
    t_in_item    ticks_to_send[$];
    t_out_item   pin_status_due[$];

    // Handshake bookkeeping shared between the clocked blocks.
    logic        in_fired   = 1'b0;
    logic        out_fired  = 1'b0;
    bit          idle_on    = 1'b1;
    int          send_gap   = 0;
    int          take_gap   = 0;
    int          quiet_cycles = 0;

    // Run statistics.
    int          ticks_pushed     = 0;
    int          ticks_taken      = 0;
    int          results_checked  = 0;
    int          mismatches       = 0;
    int          writes_started   = 0;
    int          reads_started    = 0;
    int          nacked_transfers = 0;

    i2c_master_register_access uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Load a wait of n ticks (zero stretches to one) and move to nxt.
    task automatic arm_wait(input logic [7:0] n, input t_bus_step nxt);
        bus_step  = nxt;
        wait_left = (n == 8'd0) ? 8'd1 : n;
    endtask

    // Pick what follows a finished byte: next byte, repeated start, read or stop.
    task automatic next_byte();
        if (nack_seen) begin
            bus_step = BS_STOP_SDA;
        end else if (byte_num == 3'd0) begin
            byte_num = 3'd1;
            shifter  = cmd_reg;
            bus_step = BS_WR_SETUP;
        end else if (byte_num == 3'd1) begin
            byte_num = 3'd2;
            if (cmd_is_read) begin
                bus_step = BS_START_HI;
            end else begin
                shifter  = cmd_val;
                bus_step = BS_WR_SETUP;
            end
        end else if (cmd_is_read) begin
            byte_num = 3'd4;
            bus_step = BS_RD_SETUP;
        end else begin
            bus_step = BS_STOP_SDA;
        end
    endtask

    // Run zero-time steps until one parks on a wait or the sequencer rests idle.
    task automatic run_sequence(input t_in_item t);
        logic [7:0] full_d;
        logic [7:0] half_d;
        logic       parked;
        full_d = ticks_per_phase;
        half_d = ticks_per_phase >> 1;
        for (int g = 0; g < 8; g++) begin
            parked = 1'b1;
            case (bus_step)
                BS_IDLE: begin
                    if (t.action != ACT_WRITE && t.action != ACT_READ) return;
                    cmd_is_read = (t.action == ACT_READ);
                    cmd_reg     = t.reg_address;
                    cmd_val     = t.write_value;
                    nack_seen   = 1'b0;
                    byte_num    = 3'd0;
                    bus_step    = BS_START_HI;
                    parked      = 1'b0;
                    if (cmd_is_read) reads_started++;
                    else writes_started++;
                end
                BS_START_HI: begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    arm_wait(full_d, BS_START_SDA);
                end
                BS_START_SDA: begin
                    sda_q = 1'b0;
                    arm_wait(full_d, BS_START_SCL);
                end
                BS_START_SCL: begin
                    scl_q = 1'b0;
                    // the repeated start of a read carries the read bit
                    if (byte_num == 3'd2) begin
                        byte_num = 3'd3;
                        shifter  = {dev_addr, 1'b1};
                    end else begin
                        shifter  = {dev_addr, 1'b0};
                    end
                    arm_wait(full_d, BS_WR_SETUP);
                end
                BS_WR_SETUP: begin
                    drive_q = 1'b1;
                    bit_num = 4'd0;
                    arm_wait(full_d, BS_WR_LOW);
                end
                BS_WR_LOW: begin
                    scl_q = 1'b0;
                    sda_q = shifter[3'd7 - bit_num[2:0]];
                    arm_wait(full_d, BS_WR_HIGH);
                end
                BS_WR_HIGH: begin
                    scl_q   = 1'b1;
                    bit_num = bit_num + 4'd1;
                    arm_wait(full_d, (bit_num >= 4'd8) ? BS_ACK_LOW : BS_WR_LOW);
                end
                BS_ACK_LOW: begin
                    scl_q   = 1'b0;
                    drive_q = 1'b0;
                    arm_wait(full_d, BS_ACK_HIGH);
                end
                BS_ACK_HIGH: begin
                    scl_q     = 1'b1;
                    ack_polls = 16'd0;
                    arm_wait(half_d, BS_ACK_POLL);
                end
                BS_ACK_POLL: begin
                    // keep polling one tick at a time while SDA stays high
                    if (t.sda_in && ack_polls < ack_limit) begin
                        ack_polls = ack_polls + 16'd1;
                        arm_wait(8'd1, BS_ACK_POLL);
                    end else begin
                        if (ack_polls >= ack_limit) nack_seen = 1'b1;
                        arm_wait(half_d, BS_ACK_END);
                    end
                end
                BS_ACK_END: begin
                    scl_q   = 1'b0;
                    drive_q = 1'b1;
                    next_byte();
                    parked  = 1'b0;
                end
                BS_STOP_SDA: begin
                    sda_q = 1'b0;
                    arm_wait(full_d, BS_STOP_SCL);
                end
                BS_STOP_SCL: begin
                    scl_q = 1'b1;
                    arm_wait(full_d, BS_STOP_REL);
                end
                BS_STOP_REL: begin
                    sda_q = 1'b1;
                    arm_wait(full_d, BS_DONE);
                end
                BS_RD_SETUP: begin
                    drive_q = 1'b0;
                    bit_num = 4'd0;
                    shifter = 8'd0;
                    arm_wait(full_d, BS_RD_LOW);
                end
                BS_RD_LOW: begin
                    scl_q = 1'b0;
                    arm_wait(full_d, BS_RD_HIGH);
                end
                BS_RD_HIGH: begin
                    scl_q = 1'b1;
                    arm_wait(half_d, BS_RD_SAMPLE);
                end
                BS_RD_SAMPLE: begin
                    if (t.sda_in) shifter[3'd7 - bit_num[2:0]] = 1'b1;
                    bit_num = bit_num + 4'd1;
                    arm_wait(half_d, (bit_num >= 4'd8) ? BS_NACK_LOW : BS_RD_LOW);
                end
                BS_NACK_LOW: begin
                    scl_q   = 1'b0;
                    drive_q = 1'b1;
                    sda_q   = 1'b1;
                    arm_wait(full_d, BS_NACK_HIGH);
                end
                BS_NACK_HIGH: begin
                    scl_q = 1'b1;
                    arm_wait(full_d, BS_NACK_END);
                end
                BS_NACK_END: begin
                    scl_q = 1'b0;
                    arm_wait(full_d, BS_NACK_REL);
                end
                BS_NACK_REL: begin
                    sda_q = 1'b1;
                    arm_wait(full_d, BS_RD_LATCH);
                end
                BS_RD_LATCH: begin
                    last_read = shifter;
                    bus_step  = BS_STOP_SDA;
                    parked    = 1'b0;
                end
                default: begin
                    bus_step = BS_IDLE;
                    parked   = 1'b0;
                end
            endcase
            if (parked) begin
                wait_left = wait_left - 8'd1;
                return;
            end
        end
    endtask

    // Advance the predictor by one bus tick and report the pins and status after it.
    task automatic predict_bus_tick(input t_in_item t, output t_out_item r);
        if (bus_step == BS_DONE && wait_left == 8'd0) bus_step = BS_IDLE;
        if (wait_left > 8'd0) wait_left = wait_left - 8'd1;
        else run_sequence(t);
        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_drive  = drive_q;
        r.busy_res   = (bus_step != BS_IDLE);
        r.done_res   = (bus_step == BS_DONE && wait_left == 8'd0);
        r.read_value = last_read;
        r.ack_error  = nack_seen;
    endtask

    task automatic check_field(input string what, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued ticks at the falling edge, hold each until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // drop valid only once the pending tick went through
            next_valid = i_in_valid && !in_fired;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (ticks_to_send.size() != 0) begin
                    i_in_data  <= ticks_to_send.pop_front();
                    next_valid = 1'b1;
                    send_gap   = idle_on ? $urandom_range(14, 0) : 0;
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Receiver side: while idle_on is set, stall ready for a random number of cycles after each result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_fired) take_gap = idle_on ? $urandom_range(14, 0) : 0;
            if (take_gap > 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest prediction, predict new ticks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        in_fired  <= i_rst_n && i_in_valid && o_in_ready;
        out_fired <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (pin_status_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = pin_status_due.pop_front();
                    check_field("scl_level",  8'(want.scl_level),
                                8'(o_out_data.scl_level));
                    check_field("sda_level",  8'(want.sda_level),
                                8'(o_out_data.sda_level));
                    check_field("sda_drive",  8'(want.sda_drive),
                                8'(o_out_data.sda_drive));
                    check_field("busy_res",   8'(want.busy_res),
                                8'(o_out_data.busy_res));
                    check_field("done_res",   8'(want.done_res),
                                8'(o_out_data.done_res));
                    check_field("read_value", want.read_value, o_out_data.read_value);
                    check_field("ack_error",  8'(want.ack_error),
                                8'(o_out_data.ack_error));
                    if (want.done_res && want.ack_error) nacked_transfers++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_bus_tick(i_in_data, want);
                pin_status_due.push_back(want);
                ticks_taken++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pin_status_due.size());
                $display("tb_i2c_master_register_access failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic [1:0] act, input logic [7:0] ra,
                             input logic [7:0] wv, input logic sda);
        t_in_item t;
        t.action      = act;
        t.reg_address = ra;
        t.write_value = wv;
        t.sda_in      = sda;
        ticks_to_send.push_back(t);
        ticks_pushed++;
    endtask

    function automatic logic sda_draw(input int ones_pct);
        return $urandom_range(99, 0) < ones_pct;
    endfunction

    // Mostly no command; commands land whenever the sequencer happens to be idle.
    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return ACT_NONE;
        if (r < 82) return ACT_WRITE;
        if (r < 94) return ACT_READ;
        return ACT_RESERVED;
    endfunction

    // Block until every queued tick went through; return at a rising edge.
    task automatic wait_all_taken();
        while (ticks_taken != ticks_pushed) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic wait_results_in();
        while (pin_status_due.size() != 0) @(negedge i_clk);
    endtask

    // Feed idle ticks until the predicted sequencer is back at rest.
    task automatic drain_bus(input int ones_pct);
        wait_all_taken();
        while (bus_step != BS_IDLE) begin
            repeat (32) push_tick(ACT_NONE, 8'($urandom), 8'($urandom), sda_draw(ones_pct));
            wait_all_taken();
        end
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [CfgDataWidth-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_TARGET_ADDRESS: dev_addr        = data[6:0];
            CFG_PHASE_TICKS:    ticks_per_phase = data[7:0];
            CFG_ACK_TIMEOUT:    ack_limit       = data[15:0];
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block is quiet.
    task automatic reconfigure(input logic [6:0] addr, input logic [7:0] ph,
                               input logic [15:0] tmo);
        wait_all_taken();
        wait_results_in();
        // let the output stage settle
        repeat (4) @(posedge i_clk);
        write_cfg(CFG_TARGET_ADDRESS, CfgDataWidth'(addr));
        write_cfg(CFG_PHASE_TICKS, CfgDataWidth'(ph));
        write_cfg(CFG_ACK_TIMEOUT, CfgDataWidth'(tmo));
        @(posedge i_clk);
    endtask

    // Issue one command on an idle bus, poke it with ignored commands, run it out.
    task automatic run_command(input logic [1:0] act, input logic [7:0] ra,
                               input logic [7:0] wv, input int ones_pct);
        push_tick(act, ra, wv, sda_draw(ones_pct));
        push_tick(ACT_READ, ~ra, ~wv, sda_draw(ones_pct));
        push_tick(ACT_WRITE, wv, ra, sda_draw(ones_pct));
        drain_bus(ones_pct);
    endtask

    // Random ticks under one register setting; optionally stall the sender halfway
    // until every outstanding result has come back.
    task automatic random_segment(input logic [6:0] addr, input logic [7:0] ph,
                                  input logic [15:0] tmo, input int ones_pct,
                                  input int n, input bit hold_midway);
        reconfigure(addr, ph, tmo);
        idle_on = ($urandom_range(3, 0) != 0);
        for (int k = 0; k < n; k++) begin
            if (hold_midway && k == n / 2) begin
                wait_all_taken();
                wait_results_in();
                @(posedge i_clk);
            end
            push_tick(pick_action(), 8'($urandom), 8'($urandom), sda_draw(ones_pct));
        end
        drain_bus(ones_pct);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        // Directed: reserved and empty actions on an idle bus, reset registers.
        push_tick(ACT_RESERVED, 8'hFF, 8'hFF, 1'b1);
        push_tick(ACT_NONE, 8'h00, 8'h00, 1'b0);
        run_command(ACT_WRITE, 8'hFF, 8'h00, 0);

        // Highest address, phase setting 2; a read of mostly-high data.
        reconfigure(7'h7F, 8'd2, 16'd1000);
        run_command(ACT_READ, 8'h00, 8'hFF, 90);

        // Nobody answers: write and read end on a missing ACK, read byte is held.
        reconfigure(7'h2A, 8'd2, 16'd3);
        run_command(ACT_WRITE, 8'h3C, 8'hC3, 100);
        run_command(ACT_READ, 8'h81, 8'h18, 100);

        // Zero phase and zero timeout: every wait shrinks to one tick, every ACK fails.
        reconfigure(7'h00, 8'd0, 16'd0);
        run_command(ACT_WRITE, 8'h12, 8'h34, 0);
        run_command(ACT_READ, 8'h56, 8'h78, 0);

        // One-tick phases with a one-tick ACK window.
        reconfigure(7'h01, 8'd1, 16'd1);
        run_command(ACT_READ, 8'h7E, 8'hE7, 50);

        // Random ticks across a spread of settings.
        random_segment(7'($urandom), 8'd2, 16'd1000, 50, 40, 1'b0);
        random_segment(7'h7F, 8'd1, 16'd4, 50, 40, 1'b1);
        random_segment(7'h00, 8'd1, 16'd1, 70, 40, 1'b0);
        random_segment(7'($urandom), 8'd0, 16'd0, 50, 40, 1'b0);
        random_segment(7'($urandom), 8'd1, 16'd2, 100, 40, 1'b0);

        // Longest timeout with one-tick phases: a single write, back-to-back ticks.
        reconfigure(7'h7F, 8'd1, 16'd65535);
        idle_on = 1'b0;
        run_command(ACT_WRITE, 8'($urandom), 8'($urandom), 30);

        // Wind down: all ticks taken and all results back.
        wait_all_taken();
        wait_results_in();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bus ticks: %0d register writes, %0d register reads, %0d NACKed",
                 ticks_taken, writes_started, reads_started, nacked_transfers);
        $display("checked %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("tb_i2c_master_register_access passed");
        else
            $display("tb_i2c_master_register_access failed");
        $finish;
    end

endmodule
